FILE: rtl/rlat_pkg.sv
// ============================================================================
// rlat_pkg
// Shared constants, codes and controller/datapath interface types for the
// reference-counted lookup-or-allocate table.
// ============================================================================
package rlat_pkg;

    // Table size and the widths that follow from it.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths of the request and response.
    localparam int DEV_W    = 8;
    localparam int OBJ_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int REF_W    = 8;
    localparam int STATUS_W = 2;

    // One table entry as stored in the RAM: {device, object, count}.
    localparam int ENTRY_W = DEV_W + OBJ_W + REF_W;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    // Request actions.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_DUP = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // write one zero entry of the clearing pass
        logic load;     // capture a request
        logic scan;     // scan step of a get
        logic dup_rd;   // read the entry named by a dup
        logic dup_cmp;  // evaluate the dup entry
        logic commit;   // write back and load the response register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // last entry of the clearing pass is being written
        logic scan_end;    // scan found a match or compared the last entry
        logic out_free;    // response register can take a new result
    } stat_t;

    // Low bits of a table index as they appear in the slot field.
    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

FILE: rtl/rlat_ram.sv
// ============================================================================
// rlat_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module rlat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rlat_ctrl.sv
// ============================================================================
// rlat_ctrl
// Controller state machine: clearing pass, request intake, scan or dup
// sequence, and hand-off of the result to the response register.
// ============================================================================
module rlat_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            action,
    input  rlat_pkg::stat_t stat,
    output logic            req_ready,
    output rlat_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_DUP_RD  = 3'd3;
    localparam logic [2:0] S_DUP_CMP = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == rlat_pkg::ACT_DUP) ? S_DUP_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DUP_RD:
            begin
                cmd.dup_rd = 1'b1;
                state_next = S_DUP_CMP;
            end
            S_DUP_CMP:
            begin
                cmd.dup_cmp = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rlat_dp.sv
// ============================================================================
// rlat_dp
// Datapath: request registers, scan pointers, key compare, free-slot
// tracking, pending write-back and the response register, around the
// entry RAM.
// ============================================================================
module rlat_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rlat_pkg::cmd_t                      cmd,
    output rlat_pkg::stat_t                     stat,
    input  logic [rlat_pkg::DEV_W-1:0]          device,
    input  logic [rlat_pkg::OBJ_W-1:0]          object_number,
    input  logic [rlat_pkg::SLOT_W-1:0]         slot_in,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [rlat_pkg::STATUS_W-1:0]       status,
    output logic [rlat_pkg::SLOT_W-1:0]         slot_out,
    output logic [rlat_pkg::REF_W-1:0]          ref_after,
    output logic                                saturated
);

    // Request registers.
    logic [rlat_pkg::DEV_W-1:0]        dev_reg;
    logic [rlat_pkg::OBJ_W-1:0]        obj_reg;
    logic [rlat_pkg::SLOT_W-1:0]       slot_reg;

    // Scan and clearing pointers.
    logic [rlat_pkg::CNT_W-1:0]        rd_ptr_reg;
    logic [rlat_pkg::CNT_W-1:0]        rd_ptr_next;
    logic                              cmp_valid_reg;
    logic [rlat_pkg::IDX_W-1:0]        cmp_idx_reg;
    logic                              have_free_reg;
    logic [rlat_pkg::IDX_W-1:0]        free_idx_reg;

    // Pending result and write-back.
    logic [rlat_pkg::STATUS_W-1:0]     pend_status_reg;
    logic [rlat_pkg::SLOT_W-1:0]       pend_slot_reg;
    logic [rlat_pkg::REF_W-1:0]        pend_refs_reg;
    logic                              pend_sat_reg;
    logic                              pend_we_reg;
    logic [rlat_pkg::IDX_W-1:0]        pend_waddr_reg;
    logic [rlat_pkg::ENTRY_W-1:0]      pend_wdata_reg;

    // Response register.
    logic                              out_valid_reg;
    logic [rlat_pkg::STATUS_W-1:0]     status_reg;
    logic [rlat_pkg::SLOT_W-1:0]       slot_out_reg;
    logic [rlat_pkg::REF_W-1:0]        ref_after_reg;
    logic                              saturated_reg;

    // RAM ports.
    logic                              ram_we;
    logic [rlat_pkg::IDX_W-1:0]        ram_waddr;
    logic [rlat_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [rlat_pkg::IDX_W-1:0]        ram_raddr;
    logic [rlat_pkg::ENTRY_W-1:0]      ram_rdata;

    // Decoded entry and compare results.
    logic [rlat_pkg::DEV_W-1:0]        ent_dev;
    logic [rlat_pkg::OBJ_W-1:0]        ent_obj;
    logic [rlat_pkg::REF_W-1:0]        ent_refs;
    logic                              ent_free;
    logic                              ent_sat;
    logic [rlat_pkg::REF_W-1:0]        ent_refs_inc;
    logic                              match;
    logic                              last_cmp;
    logic                              issue;
    logic [31:0]                       slot_wide;
    logic [rlat_pkg::IDX_W-1:0]        slot_idx;
    logic                              slot_in_range;
    logic                              scan_hit;
    logic                              scan_last;
    logic                              alloc_ok;
    logic [rlat_pkg::IDX_W-1:0]        alloc_idx;

    assign ent_dev      = ram_rdata[rlat_pkg::ENTRY_W-1 -: rlat_pkg::DEV_W];
    assign ent_obj      = ram_rdata[rlat_pkg::REF_W +: rlat_pkg::OBJ_W];
    assign ent_refs     = ram_rdata[rlat_pkg::REF_W-1:0];
    assign ent_free     = (ent_refs == '0);
    assign ent_sat      = (ent_refs == rlat_pkg::REF_MAX);
    assign ent_refs_inc = ent_sat ? ent_refs : ent_refs + 1'b1;

    assign match    = !ent_free && (ent_dev == dev_reg) && (ent_obj == obj_reg);
    assign last_cmp = (cmp_idx_reg == rlat_pkg::IDX_W'(rlat_pkg::ENTRIES - 1));

    assign scan_hit  = cmd.scan && cmp_valid_reg && match;
    assign scan_last = cmd.scan && cmp_valid_reg && !match && last_cmp;
    assign alloc_ok  = have_free_reg || ent_free;
    assign alloc_idx = have_free_reg ? free_idx_reg : cmp_idx_reg;

    assign slot_wide     = 32'(slot_reg);
    assign slot_idx      = slot_wide[rlat_pkg::IDX_W-1:0];
    assign slot_in_range = (slot_wide < 32'(rlat_pkg::ENTRIES));

    assign issue = cmd.scan && (rd_ptr_reg < rlat_pkg::CNT_W'(rlat_pkg::ENTRIES));

    // RAM port selection.
    always_comb
    begin
        ram_re    = issue || cmd.dup_rd;
        ram_raddr = cmd.dup_rd ? slot_idx : rd_ptr_reg[rlat_pkg::IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = pend_waddr_reg;
        ram_wdata = pend_wdata_reg;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = rd_ptr_reg[rlat_pkg::IDX_W-1:0];
            ram_wdata = '0;
        end
        else if (cmd.commit)
        begin
            ram_we = pend_we_reg;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.load)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.clear || issue)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    assign stat.clear_last = cmd.clear &&
        (rd_ptr_reg == rlat_pkg::CNT_W'(rlat_pkg::ENTRIES - 1));
    assign stat.scan_end   = scan_hit || scan_last;
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= issue;
            if (cmd.load)
            begin
                have_free_reg <= 1'b0;
            end
            else if (cmd.scan && cmp_valid_reg && ent_free)
            begin
                have_free_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dev_reg  <= device;
            obj_reg  <= object_number;
            slot_reg <= slot_in;
        end

        if (issue)
        begin
            cmp_idx_reg <= rd_ptr_reg[rlat_pkg::IDX_W-1:0];
        end

        if (cmd.scan && cmp_valid_reg && ent_free && !have_free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end

        if (scan_hit)
        begin
            pend_status_reg <= rlat_pkg::ST_HIT;
            pend_slot_reg   <= rlat_pkg::idx_to_slot(cmp_idx_reg);
            pend_refs_reg   <= ent_refs_inc;
            pend_sat_reg    <= ent_sat;
            pend_we_reg     <= !ent_sat;
            pend_waddr_reg  <= cmp_idx_reg;
            pend_wdata_reg  <= {ent_dev, ent_obj, ent_refs_inc};
        end
        else if (scan_last)
        begin
            pend_status_reg <= alloc_ok ? rlat_pkg::ST_ALLOC : rlat_pkg::ST_FULL;
            pend_slot_reg   <= alloc_ok ? rlat_pkg::idx_to_slot(alloc_idx) : '0;
            pend_refs_reg   <= alloc_ok ? rlat_pkg::REF_W'(1) : '0;
            pend_sat_reg    <= 1'b0;
            pend_we_reg     <= alloc_ok;
            pend_waddr_reg  <= alloc_idx;
            pend_wdata_reg  <= {dev_reg, obj_reg, rlat_pkg::REF_W'(1)};
        end
        else if (cmd.dup_cmp)
        begin
            pend_status_reg <= rlat_pkg::ST_HIT;
            pend_slot_reg   <= slot_reg;
            pend_refs_reg   <= slot_in_range ? ent_refs_inc : '0;
            pend_sat_reg    <= slot_in_range && ent_sat;
            pend_we_reg     <= slot_in_range && !ent_sat;
            pend_waddr_reg  <= slot_idx;
            pend_wdata_reg  <= {ent_dev, ent_obj, ent_refs_inc};
        end

        if (cmd.commit)
        begin
            status_reg    <= pend_status_reg;
            slot_out_reg  <= pend_slot_reg;
            ref_after_reg <= pend_refs_reg;
            saturated_reg <= pend_sat_reg;
        end
    end

    rlat_ram #(
        .WIDTH (rlat_pkg::ENTRY_W),
        .DEPTH (rlat_pkg::ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign ref_after = ref_after_reg;
    assign saturated = saturated_reg;

endmodule

FILE: rtl/refcounted_lookup_or_allocate_table.sv
// ============================================================================
// refcounted_lookup_or_allocate_table
// Table of keyed entries with reference counts: a get request finds a live
// entry by key or allocates the lowest free slot; a dup request raises the
// count of a given slot.
// ============================================================================
//
//  Channel    Handshake              Payload
//  ---------  ---------------------  ----------------------------------------
//  request    req_valid / req_ready  action, device, object_number, slot_in
//  response   rsp_valid / rsp_ready  status, slot_out, ref_after, saturated
//
// After reset the block runs a clearing pass that zeroes every entry;
// req_ready stays low until it ends.
// A get scans the entry RAM one entry per cycle through its single read port:
// it stops at the first live match, or else after the last entry.
// A dup reads and updates one entry.
// Results go to a response register, so a new request transfer is taken
// while the previous result still waits; a result that cannot be loaded
// because the response is stalled holds the controller until rsp_ready.
//
module refcounted_lookup_or_allocate_table (
    input  logic                              clk,
    input  logic                              rst_n,

    // Request channel.
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              action,
    input  logic [rlat_pkg::DEV_W-1:0]        device,
    input  logic [rlat_pkg::OBJ_W-1:0]        object_number,
    input  logic [rlat_pkg::SLOT_W-1:0]       slot_in,

    // Response channel.
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [rlat_pkg::STATUS_W-1:0]     status,
    output logic [rlat_pkg::SLOT_W-1:0]       slot_out,
    output logic [rlat_pkg::REF_W-1:0]        ref_after,
    output logic                              saturated
);

    // The controller and datapath talk only through these two bundles.
    rlat_pkg::cmd_t  cmd;
    rlat_pkg::stat_t stat;

    // The controller sequences the clearing pass, the scan or the dup access,
    // and the hand-off to the response register. The action only picks the
    // controller path, so the datapath never sees it.
    rlat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (action),
        .stat      (stat),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    // The datapath holds the request, the entry RAM, the compare logic and
    // the response register.
    rlat_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .device        (device),
        .object_number (object_number),
        .slot_in       (slot_in),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .slot_out      (slot_out),
        .ref_after     (ref_after),
        .saturated     (saturated)
    );

    // A full table never reports a slot or a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == rlat_pkg::ST_FULL
        |-> slot_out == '0 && ref_after == '0 && !saturated)
        else $error("table full response carries slot or count");

    // A fresh allocation always starts at a count of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == rlat_pkg::ST_ALLOC |-> ref_after == 8'd1 && !saturated)
        else $error("allocation response with wrong count");

    // Saturation is only reported on a count at its maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && saturated |-> ref_after == rlat_pkg::REF_MAX)
        else $error("saturated flag without maximum count");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // Status never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == rlat_pkg::ST_HIT || status == rlat_pkg::ST_ALLOC
                      || status == rlat_pkg::ST_FULL)
        else $error("response status out of range");

endmodule

FILE: tb/refcounted_lookup_or_allocate_table_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// refcounted_lookup_or_allocate_table_tb
// Self-checking bench for the reference-counted lookup-or-allocate table.
// It drives get and dup requests with random gaps. A shadow copy of the table
// works out every response, and a separate process checks each response
// transfer against the oldest one still awaited.
// ============================================================================
module refcounted_lookup_or_allocate_table_tb;

    // One response as the shadow table works it out.
    typedef struct packed {
        logic [rlat_pkg::STATUS_W-1:0] st;
        logic [rlat_pkg::SLOT_W-1:0]   slot;
        logic [rlat_pkg::REF_W-1:0]    refs;
        logic                          sat;
    } table_rsp_t;

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          req_valid     = 1'b0;
    logic                          req_ready;
    logic                          action        = rlat_pkg::ACT_GET;
    logic [rlat_pkg::DEV_W-1:0]    device        = '0;
    logic [rlat_pkg::OBJ_W-1:0]    object_number = '0;
    logic [rlat_pkg::SLOT_W-1:0]   slot_in       = '0;
    logic                          rsp_valid;
    logic                          rsp_ready     = 1'b0;
    logic [rlat_pkg::STATUS_W-1:0] status;
    logic [rlat_pkg::SLOT_W-1:0]   slot_out;
    logic [rlat_pkg::REF_W-1:0]    ref_after;
    logic                          saturated;

    // Shadow table. Keys of a slot are only ever read while its count is
    // above zero, so slots that were never written are never compared.
    logic [rlat_pkg::DEV_W-1:0]    tab_device [rlat_pkg::ENTRIES];
    logic [rlat_pkg::OBJ_W-1:0]    tab_object [rlat_pkg::ENTRIES];
    logic [rlat_pkg::REF_W-1:0]    tab_refs   [rlat_pkg::ENTRIES];

    // Responses that have been worked out at request transfer, oldest first.
    table_rsp_t                    awaited_rsp[$];
    int                            errors_found    = 0;

    // Idle controls of the request side and the response side.
    int                            req_max_gap     = 12;
    int                            rsp_max_gap     = 12;
    int                            rsp_hold_cycles = 0;

    refcounted_lookup_or_allocate_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .device        (device),
        .object_number (object_number),
        .slot_in       (slot_in),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .slot_out      (slot_out),
        .ref_after     (ref_after),
        .saturated     (saturated)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow table and return the response it
    // causes. A get stops at the first live entry with a matching key;
    // without a match it claims the lowest free slot, and without a free
    // slot it reports the table as full and changes nothing.
    function automatic table_rsp_t table_apply(input logic act,
                                               input logic [rlat_pkg::DEV_W-1:0] dev,
                                               input logic [rlat_pkg::OBJ_W-1:0] obj,
                                               input logic [rlat_pkg::SLOT_W-1:0] slot);
        table_rsp_t r;
        int         hit_idx;
        int         free_idx;
        r        = '0;
        hit_idx  = -1;
        free_idx = -1;
        if (act == rlat_pkg::ACT_DUP)
        begin
            r.st   = rlat_pkg::ST_HIT;
            r.slot = slot;
            // A slot beyond the table leaves everything as it is.
            if (int'(slot) >= rlat_pkg::ENTRIES)
                return r;
            if (tab_refs[slot] == rlat_pkg::REF_MAX)
                r.sat = 1'b1;
            else
                tab_refs[slot] = tab_refs[slot] + 1'b1;
            r.refs = tab_refs[slot];
            return r;
        end
        for (int i = 0; i < rlat_pkg::ENTRIES; i++)
        begin
            if (tab_refs[i] != '0 && tab_device[i] == dev && tab_object[i] == obj)
            begin
                hit_idx = i;
                break;
            end
            if (free_idx < 0 && tab_refs[i] == '0)
                free_idx = i;
        end
        if (hit_idx >= 0)
        begin
            r.st   = rlat_pkg::ST_HIT;
            r.slot = rlat_pkg::SLOT_W'(hit_idx);
            if (tab_refs[hit_idx] == rlat_pkg::REF_MAX)
                r.sat = 1'b1;
            else
                tab_refs[hit_idx] = tab_refs[hit_idx] + 1'b1;
            r.refs = tab_refs[hit_idx];
        end
        else if (free_idx < 0)
        begin
            r.st = rlat_pkg::ST_FULL;
        end
        else
        begin
            tab_device[free_idx] = dev;
            tab_object[free_idx] = obj;
            tab_refs[free_idx]   = rlat_pkg::REF_W'(1);
            r.st   = rlat_pkg::ST_ALLOC;
            r.slot = rlat_pkg::SLOT_W'(free_idx);
            r.refs = rlat_pkg::REF_W'(1);
        end
        return r;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < rlat_pkg::ENTRIES; i++)
            if (tab_refs[i] != '0)
                n++;
        return n;
    endfunction

    // A random live slot. Dups only ever target slots whose key was written,
    // since a dup that woke up a never-written slot would leave a live entry
    // with an unknown key for later gets to compare against.
    function automatic int pick_live_slot();
        int s;
        s = $urandom_range(rlat_pkg::ENTRIES - 1, 0);
        while (tab_refs[s] == '0)
            s = $urandom_range(rlat_pkg::ENTRIES - 1, 0);
        return s;
    endfunction

    // Offer one request after a random gap and hold it until the transfer.
    // The valid is left high on return, so a following request with no gap
    // keeps it high without a drop in between.
    task automatic send_request(input logic act,
                                input logic [rlat_pkg::DEV_W-1:0] dev,
                                input logic [rlat_pkg::OBJ_W-1:0] obj,
                                input logic [rlat_pkg::SLOT_W-1:0] slot);
        int gap;
        gap = $urandom_range(req_max_gap, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action        <= act;
        device        <= dev;
        object_number <= obj;
        slot_in       <= slot;
        req_valid     <= 1'b1;
        do @(posedge clk); while (!(req_valid && req_ready === 1'b1));
        awaited_rsp.push_back(table_apply(act, dev, obj, slot));
    endtask

    // A get carries a random slot field and a dup random key fields, since
    // the block must ignore them.
    task automatic send_get(input logic [rlat_pkg::DEV_W-1:0] dev,
                            input logic [rlat_pkg::OBJ_W-1:0] obj);
        send_request(rlat_pkg::ACT_GET, dev, obj, rlat_pkg::SLOT_W'($urandom));
    endtask

    task automatic send_dup(input int slot);
        send_request(rlat_pkg::ACT_DUP, rlat_pkg::DEV_W'($urandom),
                     rlat_pkg::OBJ_W'($urandom), rlat_pkg::SLOT_W'(slot));
    endtask

    task automatic send_live_key();
        int s;
        s = pick_live_slot();
        send_get(tab_device[s], tab_object[s]);
    endtask

    // Keys at the corners of both fields, keys that differ from a stored one
    // in a single field, hits on them and dups of stored slots.
    task automatic test_key_extremes();
        send_get(8'h00, 16'h0000);
        send_get(8'hFF, 16'hFFFF);
        send_get(8'h00, 16'hFFFF);
        send_get(8'hFF, 16'h0000);
        send_get(8'h00, 16'h0000);
        send_get(8'hFF, 16'hFFFF);
        send_get(8'h01, 16'h0000);
        send_get(8'h00, 16'h0001);
        send_get(8'h80, 16'h0000);
        send_get(8'h00, 16'h8000);
        send_dup(3);
        send_dup(0);
        send_get(8'hFF, 16'h0000);
        send_get(8'h80, 16'h0000);
        send_dup(7);
    endtask

    // Drive one count up to its maximum and beyond, by dups and by gets of
    // its key, so that both kinds of request meet a saturated count.
    task automatic test_count_saturation();
        for (int n = 0; n < 262; n++)
        begin
            if ($urandom_range(1, 0) == 0)
                send_dup(1);
            else
                send_get(8'hFF, 16'hFFFF);
        end
    endtask

    // Hold the response side off for a long stretch while requests keep
    // coming with no gaps, so the block fills up and drops req_ready.
    task automatic test_response_backpressure();
        req_max_gap     = 0;
        rsp_hold_cycles = 300;
        for (int n = 0; n < 24; n++)
        begin
            if ($urandom_range(1, 0) == 0)
                send_live_key();
            else
                send_dup(pick_live_slot());
        end
        req_max_gap = 12;
    endtask

    // Mostly hits and dups on stored slots, with a trickle of new keys and
    // of keys one bit away from a stored one. The trickle fills the table
    // part way through, so the later part also meets a full table. The idle
    // pattern of both sides is redrawn every hundred requests.
    task automatic test_random_traffic();
        int            pick;
        int            s;
        logic [23:0]   near_key;
        for (int n = 0; n < 1300; n++)
        begin
            if (n % 100 == 0)
            begin
                req_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 12;
                rsp_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 12;
            end
            pick = $urandom_range(99, 0);
            if (pick < 3)
            begin
                send_get(rlat_pkg::DEV_W'($urandom), rlat_pkg::OBJ_W'($urandom));
            end
            else if (pick < 7)
            begin
                s        = pick_live_slot();
                near_key = {tab_device[s], tab_object[s]}
                           ^ (24'h1 << $urandom_range(23, 0));
                send_get(near_key[23:16], near_key[15:0]);
            end
            else if (pick < 55)
            begin
                send_live_key();
            end
            else
            begin
                send_dup(pick_live_slot());
            end
        end
        req_max_gap = 12;
        rsp_max_gap = 12;
    endtask

    // Fill every slot, then mix misses on the full table with hits, dups of
    // any slot and gets of the key that sits in the last slot scanned.
    task automatic test_table_full();
        while (live_count() < rlat_pkg::ENTRIES)
            send_get(rlat_pkg::DEV_W'($urandom), rlat_pkg::OBJ_W'($urandom));
        send_dup(0);
        send_dup(rlat_pkg::ENTRIES - 1);
        for (int n = 0; n < 40; n++)
        begin
            case ($urandom_range(3, 0))
                0: send_get(rlat_pkg::DEV_W'($urandom), rlat_pkg::OBJ_W'($urandom));
                1: send_live_key();
                2: send_dup($urandom_range(rlat_pkg::ENTRIES - 1, 0));
                default: send_get(tab_device[rlat_pkg::ENTRIES-1],
                                  tab_object[rlat_pkg::ENTRIES-1]);
            endcase
        end
    endtask

    // Response side: after a random gap, or the long hold that the
    // backpressure test asks for, it raises rsp_ready and checks the
    // transfer against the oldest awaited response.
    initial
    begin : rsp_side
        int         gap;
        table_rsp_t want;
        while (rst_n !== 1'b1) @(negedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                gap             = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                gap = $urandom_range(rsp_max_gap, 0);
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_ready));
            if (awaited_rsp.size() == 0)
            begin
                $error("response transfer with none awaited: status %0d slot_out %0d",
                       status, slot_out);
                errors_found++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    errors_found++;
                end
                if (slot_out !== want.slot)
                begin
                    $error("slot_out: expected %0d, actual %0d", want.slot, slot_out);
                    errors_found++;
                end
                if (ref_after !== want.refs)
                begin
                    $error("ref_after: expected %0d, actual %0d", want.refs, ref_after);
                    errors_found++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %0d, actual %0d", want.sat, saturated);
                    errors_found++;
                end
            end
            @(negedge clk);
        end
    end

    // Main sequence. The block clears its table after reset with req_ready
    // low, which the request handshake simply waits out.
    initial
    begin : main_seq
        for (int i = 0; i < rlat_pkg::ENTRIES; i++)
            tab_refs[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_key_extremes();
        test_count_saturation();
        test_response_backpressure();
        test_random_traffic();
        test_table_full();

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        // Give a stray response time to show up.
        repeat (rlat_pkg::ENTRIES + 16) @(posedge clk);
        if (awaited_rsp.size() != 0)
            errors_found++;

        if (errors_found == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of the whole sequence.
    initial
    begin : watchdog
        #(64'd20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rlat_pkg.sv
rtl/rlat_ram.sv
rtl/rlat_ctrl.sv
rtl/rlat_dp.sv
rtl/refcounted_lookup_or_allocate_table.sv
tb/refcounted_lookup_or_allocate_table_tb.sv
